[rtl/core/vers_pkg.sv]
`timescale 1ns / 1ps

package vers_pkg;

  // Field and datapath widths
  localparam int CRD_W     = 32;          // Q16.16 coordinate
  localparam int ANG_W     = 10;          // signed whole degrees
  localparam int TRIG_W    = 16;          // Q1.15 sine / cosine
  localparam int SCL_W     = 16;          // Q8.8 scale
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int QT_W      = CRD_W + 1;   // signed translation quotient

  // Coordinate width after each rotation (one bit of growth per rotation)
  localparam int ROTX_W = CRD_W + 1;
  localparam int ROTY_W = ROTX_W + 1;
  localparam int ROTZ_W = ROTY_W + 1;
  localparam int FIN_W  = ROTZ_W;

  localparam int SMOOTH_DIVISOR_DEF = 25;

  localparam logic [SCL_W-1:0]         SCALE_ONE = SCL_W'(256);
  localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 16'sd32767;
  localparam logic signed [11:0]       DEG_FULL  = 12'sd360;
  localparam logic signed [11:0]       DEG_TWICE = 12'sd720;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_SCALE   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;
  } vertex_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] out_x;
    logic signed [CRD_W-1:0] out_y;
    logic signed [CRD_W-1:0] out_z;
  } result_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // Quarter-wave sine, round(32768*sin(d)), held at 32767 at 90 degrees
  localparam logic [14:0] SIN_QUARTER [0:90] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
    15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
    15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
    15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
    15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
    15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
    15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
    15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622,
    15'd21063, 15'd21498, 15'd21926, 15'd22348, 15'd22763,
    15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730,
    15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510,
    15'd26842, 15'd27166, 15'd27482, 15'd27789, 15'd28088,
    15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
    15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
    15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499,
    15'd31651, 15'd31795, 15'd31928, 15'd32052, 15'd32166,
    15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32588,
    15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763,
    15'd32767
  };

  // Reduce a 10-bit signed angle to 0..359
  function automatic logic [8:0] deg_wrap(logic signed [ANG_W-1:0] d);
    logic signed [11:0] t;
    t = 12'(d);
    if (t < -DEG_FULL) begin
      t = t + DEG_TWICE;
    end else if (t < 12'sd0) begin
      t = t + DEG_FULL;
    end else if (t >= DEG_FULL) begin
      t = t - DEG_FULL;
    end
    return t[8:0];
  endfunction

  function automatic logic signed [TRIG_W-1:0] sin_deg(logic [8:0] d);
    logic [8:0]  idx;
    logic        neg;
    logic [14:0] mag;
    if (d <= 9'd90) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 9'd180 - d;
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = d - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - d;
      neg = 1'b1;
    end
    mag = SIN_QUARTER[idx[6:0]];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_deg(logic [8:0] d);
    logic [9:0] e;
    e = {1'b0, d} + 10'd90;
    if (e >= 10'd360) begin
      e = e - 10'd360;
    end
    return sin_deg(e[8:0]);
  endfunction

endpackage

[rtl/core/vertex_euler_rotate_scale_translate.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// vertex    in         vertex_valid / vertex_stall  vers_pkg::vertex_t (x, y, z Q16.16)
// result    out        result_valid / result_stall  vers_pkg::result_t (x, y, z Q16.16)
// cfg       in         cfg_we (no stall)            cfg_index, cfg_data
//
// One transaction per cycle while result_stall is low; a result is registered through
// the input register, three two-stage rotations and a three-stage finish.
// Translation quotients come from a reciprocal-multiply divider per axis: ready
// after a shift write, ahead of any vertex taken after that write.
// rst is synchronous: clears all valids and loads the register defaults.
// Every stage holds while the next one is full and stalled; empty stages fill
// behind a stalled result, so bubbles close up.
module vertex_euler_rotate_scale_translate #(
  parameter int SMOOTH_DIVISOR = vers_pkg::SMOOTH_DIVISOR_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vertex_valid,
  output logic                              vertex_stall,
  input  vers_pkg::vertex_t                 vertex,
  output logic                              result_valid,
  input  logic                              result_stall,
  output vers_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [vers_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vers_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW  = vers_pkg::CRD_W;
  localparam int XW  = vers_pkg::ROTX_W;
  localparam int YW  = vers_pkg::ROTY_W;
  localparam int ZW  = vers_pkg::ROTZ_W;
  localparam int AGW = vers_pkg::ANG_W;

  // Configuration registers
  logic signed [AGW-1:0]            rot_x;
  logic signed [AGW-1:0]            rot_y;
  logic signed [AGW-1:0]            rot_z;
  logic [vers_pkg::SCL_W-1:0]       scale;
  logic                             start_x;
  logic                             start_y;
  logic                             start_z;

  vers_pkg::trig_t                  trig_x;
  vers_pkg::trig_t                  trig_y;
  vers_pkg::trig_t                  trig_z;
  logic signed [vers_pkg::QT_W-1:0] q_x;
  logic signed [vers_pkg::QT_W-1:0] q_y;
  logic signed [vers_pkg::QT_W-1:0] q_z;

  // Input register
  logic                             p0_valid;
  logic                             p0_ready;
  vers_pkg::vertex_t                p0;

  // Rotation chain
  logic                             rx_ready;
  logic                             rx_valid;
  logic signed [XW-1:0]             y1;
  logic signed [XW-1:0]             z1;
  logic signed [CW-1:0]             x1;
  logic                             ry_ready;
  logic                             ry_valid;
  logic signed [YW-1:0]             x2;
  logic signed [YW-1:0]             z2;
  logic signed [XW-1:0]             y2;
  logic                             rz_ready;
  logic                             rz_valid;
  logic signed [ZW-1:0]             x3;
  logic signed [ZW-1:0]             y3;
  logic signed [YW-1:0]             z3;
  logic                             fin_ready;

  // Config writes; translation goes straight to its divider
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x <= '0;
      rot_y <= '0;
      rot_z <= '0;
      scale <= vers_pkg::SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        vers_pkg::REG_ROT_X: rot_x <= cfg_data[AGW-1:0];
        vers_pkg::REG_ROT_Y: rot_y <= cfg_data[AGW-1:0];
        vers_pkg::REG_ROT_Z: rot_z <= cfg_data[AGW-1:0];
        vers_pkg::REG_SCALE: scale <= cfg_data[vers_pkg::SCL_W-1:0];
        default: ;
      endcase
    end
  end

  assign start_x = cfg_we && (cfg_index == vers_pkg::REG_SHIFT_X);
  assign start_y = cfg_we && (cfg_index == vers_pkg::REG_SHIFT_Y);
  assign start_z = cfg_we && (cfg_index == vers_pkg::REG_SHIFT_Z);

  vers_trig u_trig_x (.clk(clk), .rst(rst), .angle(rot_x), .trig(trig_x));
  vers_trig u_trig_y (.clk(clk), .rst(rst), .angle(rot_y), .trig(trig_y));
  vers_trig u_trig_z (.clk(clk), .rst(rst), .angle(rot_z), .trig(trig_z));

  vers_div #(.Divisor(SMOOTH_DIVISOR)) u_div_x (
    .clk(clk), .rst(rst), .start(start_x), .shift_val(cfg_data[CW-1:0]), .quot(q_x)
  );
  vers_div #(.Divisor(SMOOTH_DIVISOR)) u_div_y (
    .clk(clk), .rst(rst), .start(start_y), .shift_val(cfg_data[CW-1:0]), .quot(q_y)
  );
  vers_div #(.Divisor(SMOOTH_DIVISOR)) u_div_z (
    .clk(clk), .rst(rst), .start(start_z), .shift_val(cfg_data[CW-1:0]), .quot(q_z)
  );

  // Input register: lets the trig registers settle after an angle write
  assign p0_ready     = !p0_valid || rx_ready;
  assign vertex_stall = !p0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (p0_ready) begin
      p0_valid <= vertex_valid;
    end
    if (p0_ready && vertex_valid) begin
      p0 <= vertex;
    end
  end

  // About X: (y, z)
  vers_rot #(.AW(CW), .BW(CW), .PW(CW)) u_rot_x (
    .clk(clk), .rst(rst), .trig(trig_x),
    .in_valid(p0_valid), .in_ready(rx_ready),
    .a_in(p0.coord_y), .b_in(p0.coord_z), .pass_in(p0.coord_x),
    .out_valid(rx_valid), .out_ready(ry_ready),
    .a_out(y1), .b_out(z1), .pass_out(x1)
  );

  // About Y: (x, z)
  vers_rot #(.AW(CW), .BW(XW), .PW(XW)) u_rot_y (
    .clk(clk), .rst(rst), .trig(trig_y),
    .in_valid(rx_valid), .in_ready(ry_ready),
    .a_in(x1), .b_in(z1), .pass_in(y1),
    .out_valid(ry_valid), .out_ready(rz_ready),
    .a_out(x2), .b_out(z2), .pass_out(y2)
  );

  // About Z: (x, y)
  vers_rot #(.AW(YW), .BW(XW), .PW(YW)) u_rot_z (
    .clk(clk), .rst(rst), .trig(trig_z),
    .in_valid(ry_valid), .in_ready(rz_ready),
    .a_in(x2), .b_in(y2), .pass_in(z2),
    .out_valid(rz_valid), .out_ready(fin_ready),
    .a_out(x3), .b_out(y3), .pass_out(z3)
  );

  vers_fin u_fin (
    .clk(clk), .rst(rst),
    .in_valid(rz_valid), .in_ready(fin_ready),
    .cx(x3), .cy(y3), .cz(ZW'(z3)),
    .scale(scale), .qx(q_x), .qy(q_y), .qz(q_z),
    .out_valid(result_valid), .out_stall(result_stall), .result(result)
  );

endmodule

[rtl/core/vers_trig.sv]
`timescale 1ns / 1ps

// Angle register to registered sine / cosine
module vers_trig (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [vers_pkg::ANG_W-1:0] angle,
  output vers_pkg::trig_t                   trig
);

  logic [8:0] deg;

  assign deg = vers_pkg::deg_wrap(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      trig.sin_v <= '0;
      trig.cos_v <= vers_pkg::TRIG_ONE;
    end else begin
      trig.sin_v <= vers_pkg::sin_deg(deg);
      trig.cos_v <= vers_pkg::cos_deg(deg);
    end
  end

endmodule

[rtl/core/vers_rot.sv]
`timescale 1ns / 1ps

// One plane rotation, two stages: products, then sum and round.
// a' = a*c + b*s, b' = b*c - a*s, rounded half up from Q.31 to Q.16
module vers_rot #(
  parameter int AW = vers_pkg::CRD_W,
  parameter int BW = vers_pkg::CRD_W,
  parameter int PW = vers_pkg::CRD_W,
  localparam int W  = (AW > BW) ? AW : BW,
  localparam int OW = W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vers_pkg::trig_t      trig,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [AW-1:0] a_in,
  input  logic signed [BW-1:0] b_in,
  input  logic signed [PW-1:0] pass_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [OW-1:0] a_out,
  output logic signed [OW-1:0] b_out,
  output logic signed [PW-1:0] pass_out
);

  localparam int TW = vers_pkg::TRIG_W;
  localparam int SW = W + TW + 1;
  localparam logic signed [SW-1:0] HALF_LSB = SW'(16384);

  logic                    s1_valid;
  logic                    s1_ready;
  logic                    s2_ready;
  logic signed [AW+TW-1:0] ac;
  logic signed [AW+TW-1:0] as;
  logic signed [BW+TW-1:0] bc;
  logic signed [BW+TW-1:0] bs;
  logic signed [PW-1:0]    pass1;
  logic signed [SW-1:0]    sum_a;
  logic signed [SW-1:0]    sum_b;
  logic signed [SW-1:0]    shr_a;
  logic signed [SW-1:0]    shr_b;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      ac    <= a_in * trig.cos_v;
      as    <= a_in * trig.sin_v;
      bc    <= b_in * trig.cos_v;
      bs    <= b_in * trig.sin_v;
      pass1 <= pass_in;
    end
  end

  always_comb begin
    sum_a = SW'(ac) + SW'(bs) + HALF_LSB;
    sum_b = SW'(bc) - SW'(as) + HALF_LSB;
    shr_a = sum_a >>> 15;
    shr_b = sum_b >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      a_out    <= shr_a[OW-1:0];
      b_out    <= shr_b[OW-1:0];
      pass_out <= pass1;
    end
  end

endmodule

[rtl/core/vers_div.sv]
`timescale 1ns / 1ps

// Translation quotient round(shift / Divisor), ties away from zero,
// as floor((2|t| + D) / 2D) with the sign put back.
// Reciprocal multiply, the numerator split in two halves over consecutive
// cycles; quot updates after the sum and sign states, and a new start restarts.
module vers_div #(
  parameter int Divisor = vers_pkg::SMOOTH_DIVISOR_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [vers_pkg::CRD_W-1:0]       shift_val,
  output logic signed [vers_pkg::QT_W-1:0] quot
);

  localparam int CW   = vers_pkg::CRD_W;
  localparam int NW   = CW + 1;                 // numerator 2|t| + D
  localparam int M    = 2 * Divisor;
  localparam int SH   = NW + $clog2(M);         // exact for every NW-bit numerator
  localparam int RCW  = NW + 1;
  localparam int LO_W = 17;
  localparam int MPW  = LO_W + RCW;
  localparam int PW   = NW + RCW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(M) - 64'd1) / 64'(M);
  localparam logic [RCW-1:0] RECIP_W = RCW'(RECIP);

  typedef enum logic [4:0] {
    DIV_IDLE = 5'b00001,
    DIV_LO   = 5'b00010,
    DIV_HI   = 5'b00100,
    DIV_SUM  = 5'b01000,
    DIV_SIGN = 5'b10000
  } div_state_t;

  div_state_t       state;
  logic [NW-1:0]    num;
  logic             neg;
  logic [MPW-1:0]   prod_lo;
  logic [MPW-1:0]   prod_hi;
  logic [CW-1:0]    mag;

  logic [CW-1:0]    mag_in;
  logic [NW-1:0]    num_init;
  logic [LO_W-1:0]  mul_a;
  logic [MPW-1:0]   mul_p;
  logic [PW-1:0]    acc;
  logic [PW-1:0]    shr;

  assign mag_in   = shift_val[CW-1] ? (CW'(0) - shift_val) : shift_val;
  assign num_init = {mag_in, 1'b0} + NW'(Divisor);

  // one multiplier, low half first, then high half
  assign mul_a = (state == DIV_HI) ? LO_W'(num[NW-1:LO_W]) : num[LO_W-1:0];
  assign mul_p = MPW'(mul_a) * MPW'(RECIP_W);
  assign acc   = PW'(prod_lo) + (PW'(prod_hi) << LO_W);
  assign shr   = acc >> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      quot  <= '0;
    end else if (start) begin
      num   <= num_init;
      neg   <= shift_val[CW-1];
      state <= DIV_LO;
    end else begin
      case (state)
        DIV_LO: begin
          prod_lo <= mul_p;
          state   <= DIV_HI;
        end
        DIV_HI: begin
          prod_hi <= mul_p;
          state   <= DIV_SUM;
        end
        DIV_SUM: begin
          mag   <= shr[CW-1:0];
          state <= DIV_SIGN;
        end
        DIV_SIGN: begin
          quot  <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          state <= DIV_IDLE;
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/vers_fin.sv]
`timescale 1ns / 1ps

// Scale, round, translate and saturate; three stages, last one is the
// output register.
module vers_fin (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [vers_pkg::FIN_W-1:0] cx,
  input  logic signed [vers_pkg::FIN_W-1:0] cy,
  input  logic signed [vers_pkg::FIN_W-1:0] cz,
  input  logic [vers_pkg::SCL_W-1:0]        scale,
  input  logic signed [vers_pkg::QT_W-1:0]  qx,
  input  logic signed [vers_pkg::QT_W-1:0]  qy,
  input  logic signed [vers_pkg::QT_W-1:0]  qz,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vers_pkg::result_t                 result
);

  localparam int FW     = vers_pkg::FIN_W;
  localparam int CW     = vers_pkg::CRD_W;
  localparam int PROD_W = FW + vers_pkg::SCL_W + 1;
  localparam int RND_W  = PROD_W - 8;
  localparam int SUM_W  = RND_W + 1;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(128);
  localparam logic signed [SUM_W-1:0]  SAT_HI   = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]  SAT_LO   = SUM_W'(-64'sd2147483648);

  logic                     f1_valid;
  logic                     f2_valid;
  logic                     f1_ready;
  logic                     f2_ready;
  logic                     f3_ready;
  logic signed [FW-1:0]     c_in [3];
  logic signed [PROD_W-1:0] prod [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [RND_W-1:0]  rnd  [3];
  logic signed [SUM_W-1:0]  q_ext [3];
  logic signed [SUM_W-1:0]  sum  [3];
  logic signed [CW-1:0]     sat  [3];
  logic signed [vers_pkg::SCL_W:0] scale_s;

  assign c_in[0] = cx;
  assign c_in[1] = cy;
  assign c_in[2] = cz;
  assign q_ext[0] = SUM_W'(qx);
  assign q_ext[1] = SUM_W'(qy);
  assign q_ext[2] = SUM_W'(qz);
  assign scale_s  = $signed({1'b0, scale});

  assign f3_ready = !out_valid || !out_stall;
  assign f2_ready = !f2_valid || f3_ready;
  assign f1_ready = !f1_valid || f2_ready;
  assign in_ready = f1_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] = (prod[i] + HALF_LSB) >>> 8;
      sum[i]    = SUM_W'(rnd[i]) + q_ext[i];
      if (sum[i] > SAT_HI) begin
        sat[i] = SAT_HI[CW-1:0];
      end else if (sum[i] < SAT_LO) begin
        sat[i] = SAT_LO[CW-1:0];
      end else begin
        sat[i] = sum[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (f1_ready) begin
        f1_valid <= in_valid;
      end
      if (f2_ready) begin
        f2_valid <= f1_valid;
      end
      if (f3_ready) begin
        out_valid <= f2_valid;
      end
    end
    if (f1_ready && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= c_in[i] * scale_s;
      end
    end
    if (f2_ready && f1_valid) begin
      for (int i = 0; i < 3; i++) begin
        rnd[i] <= prod_r[i][RND_W-1:0];
      end
    end
    if (f3_ready && f2_valid) begin
      result.out_x <= sat[0];
      result.out_y <= sat[1];
      result.out_z <= sat[2];
    end
  end

endmodule

[rtl/core/vers_chk.sv]
`timescale 1ns / 1ps

module vers_chk (
  input logic              clk,
  input logic              rst,
  input logic              vertex_stall,
  input logic              result_valid,
  input logic              result_stall,
  input vers_pkg::result_t result
);

  // Reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set right after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed");

  // With the output free the whole pipe advances, so input is never stalled
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid || !result_stall |-> !vertex_stall)
    else $error("vertex stalled while output can move");

  // Result valid only drops after a taken transaction
  a_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> $past(!result_stall || rst))
    else $error("result transaction dropped while stalled");

endmodule

bind vertex_euler_rotate_scale_translate vers_chk u_vers_chk (
  .clk(clk),
  .rst(rst),
  .vertex_stall(vertex_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result(result)
);

[verif/vertex_euler_rotate_scale_translate_tb.sv]
`timescale 1ns / 1ps

module vertex_euler_rotate_scale_translate_tb;

  localparam int     NUDGE_DIV       = 25;      // translation divisor, as built
  localparam int     WATCHDOG_LIMIT  = 4000;    // quiet cycles before giving up
  localparam int     LONG_HOLD       = 64;      // result side hold-off, cycles
  localparam int     DRAIN_TAIL      = 24;      // idle tail after the final drain
  localparam int     SETS_PER_REGIME = 4;
  localparam int     ITEMS_PER_SET   = 75;
  localparam longint COORD_MAX       = 64'sd2147483647;
  localparam longint COORD_MIN       = -64'sd2147483648;

  // write to an index past the register map; the block must drop it
  localparam logic [vers_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Q1.15 quarter-wave sine, whole degrees 0..90, 90 held at 32767
  localparam int SINE_Q15 [0:90] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32767
  };

  // one full register image, raw 32-bit write data per register
  typedef struct packed {
    logic [vers_pkg::CFG_W-1:0] rot_x;
    logic [vers_pkg::CFG_W-1:0] rot_y;
    logic [vers_pkg::CFG_W-1:0] rot_z;
    logic [vers_pkg::CFG_W-1:0] scale;
    logic [vers_pkg::CFG_W-1:0] shift_x;
    logic [vers_pkg::CFG_W-1:0] shift_y;
    logic [vers_pkg::CFG_W-1:0] shift_z;
  } xform_setting_t;

  // Predicts the transformed vertex for every accepted input and checks
  // results in order against it.
  class xform_scoreboard;
    logic [vers_pkg::ANG_W-1:0] rot_x, rot_y, rot_z;
    logic [vers_pkg::SCL_W-1:0] scale;
    logic [vers_pkg::CRD_W-1:0] shift_x, shift_y, shift_z;
    vers_pkg::result_t          pending_results[$];
    int                         mismatches;

    function new();
      rot_x      = '0;
      rot_y      = '0;
      rot_z      = '0;
      scale      = vers_pkg::SCALE_ONE;
      shift_x    = '0;
      shift_y    = '0;
      shift_z    = '0;
      mismatches = 0;
    endfunction

    // upper bits beyond each register's width are dropped
    function void set_reg(logic [vers_pkg::CFG_IDX_W-1:0] idx,
                          logic [vers_pkg::CFG_W-1:0] data);
      case (idx)
        vers_pkg::REG_ROT_X:   rot_x   = data[vers_pkg::ANG_W-1:0];
        vers_pkg::REG_ROT_Y:   rot_y   = data[vers_pkg::ANG_W-1:0];
        vers_pkg::REG_ROT_Z:   rot_z   = data[vers_pkg::ANG_W-1:0];
        vers_pkg::REG_SCALE:   scale   = data[vers_pkg::SCL_W-1:0];
        vers_pkg::REG_SHIFT_X: shift_x = data;
        vers_pkg::REG_SHIFT_Y: shift_y = data;
        vers_pkg::REG_SHIFT_Z: shift_z = data;
        default:               ;
      endcase
    endfunction

    function int sine_at(int d);
      if (d <= 90) return SINE_Q15[d];
      if (d <= 180) return SINE_Q15[180 - d];
      if (d <= 270) return -SINE_Q15[d - 180];
      return -SINE_Q15[360 - d];
    endfunction

    // a' = a*c + b*s, b' = -a*s + b*c, each rounded half up back to Q16.16
    function void turn(inout longint a, inout longint b,
                       input logic [vers_pkg::ANG_W-1:0] raw);
      int     d, s, c;
      longint na, nb;
      d = int'($signed(raw)) % 360;
      if (d < 0) d += 360;
      s  = sine_at(d);
      c  = sine_at((d + 90) % 360);
      na = a * c + b * s;
      nb = -a * s + b * c;
      a  = (na + 16384) >>> 15;
      b  = (nb + 16384) >>> 15;
    endfunction

    function logic [vers_pkg::CRD_W-1:0] scale_and_shift(longint v,
                                                         logic [vers_pkg::CRD_W-1:0] shift_raw);
      longint t, q, r, sc;
      sc = scale;
      t  = $signed(shift_raw);
      r  = (v * sc + 128) >>> 8;
      // shift / divisor, nearest, ties away from zero
      if (t >= 0) q = (2 * t + NUDGE_DIV) / (2 * NUDGE_DIV);
      else        q = -((-2 * t + NUDGE_DIV) / (2 * NUDGE_DIV));
      r += q;
      if (r > COORD_MAX) r = COORD_MAX;
      if (r < COORD_MIN) r = COORD_MIN;
      return r[vers_pkg::CRD_W-1:0];
    endfunction

    function void note_vertex(vers_pkg::vertex_t v);
      longint            x, y, z;
      vers_pkg::result_t e;
      x = $signed(v.coord_x);
      y = $signed(v.coord_y);
      z = $signed(v.coord_z);
      turn(y, z, rot_x);
      turn(x, z, rot_y);
      turn(x, y, rot_z);
      e.out_x = scale_and_shift(x, shift_x);
      e.out_y = scale_and_shift(y, shift_y);
      e.out_z = scale_and_shift(z, shift_z);
      pending_results.insert(pending_results.size(), e);
    endfunction

    function void check_result(vers_pkg::result_t r);
      vers_pkg::result_t e;
      if (pending_results.size() == 0) begin
        $error("result transaction with no vertex outstanding: %h", r);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (r.out_x !== e.out_x) begin
        $error("out_x expected %h actual %h", e.out_x, r.out_x);
        mismatches++;
      end
      if (r.out_y !== e.out_y) begin
        $error("out_y expected %h actual %h", e.out_y, r.out_y);
        mismatches++;
      end
      if (r.out_z !== e.out_z) begin
        $error("out_z expected %h actual %h", e.out_z, r.out_z);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           vertex_valid = 1'b0;
  logic                           vertex_stall;
  vers_pkg::vertex_t              vertex = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  vers_pkg::result_t              result;
  logic                           cfg_we = 1'b0;
  logic [vers_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vers_pkg::CFG_W-1:0]     cfg_data = '0;

  xform_scoreboard board;

  // idle odds in percent, changed by the stimulus between regimes
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  // stimulus bumps hold_requests; the result side serves each one with a hold-off
  int hold_requests = 0;

  vertex_euler_rotate_scale_translate u_dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result side: checks every accepted transaction against the oldest
  // prediction, then picks the stall for the next cycle. A pending hold
  // request turns into a LONG_HOLD countdown of solid stall so the pipeline backs
  // up all the way to the vertex input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) board.check_result(result);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (vertex_valid && !vertex_stall) || (result_valid && !result_stall) ||
          cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one vertex, with random idle cycles ahead of it; returns in the
  // step of acceptance with valid still high.
  task automatic send_vertex(input vers_pkg::vertex_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex       <= v;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
    board.note_vertex(v);
  endtask

  // Sender pause: hold off until every predicted result has come back.
  task automatic wait_drained();
    vertex_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [vers_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vers_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic load_setting(input xform_setting_t s, input bit poke_unused);
    write_reg(vers_pkg::REG_ROT_X, s.rot_x);
    write_reg(vers_pkg::REG_ROT_Y, s.rot_y);
    write_reg(vers_pkg::REG_ROT_Z, s.rot_z);
    write_reg(vers_pkg::REG_SCALE, s.scale);
    write_reg(vers_pkg::REG_SHIFT_X, s.shift_x);
    write_reg(vers_pkg::REG_SHIFT_Y, s.shift_y);
    write_reg(vers_pkg::REG_SHIFT_Z, s.shift_z);
    if (poke_unused) write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
  endtask

  function automatic vers_pkg::vertex_t mk_vertex(logic [vers_pkg::CRD_W-1:0] x,
                                                  logic [vers_pkg::CRD_W-1:0] y,
                                                  logic [vers_pkg::CRD_W-1:0] z);
    vers_pkg::vertex_t v;
    v.coord_x = x;
    v.coord_y = y;
    v.coord_z = z;
    return v;
  endfunction

  function automatic logic [vers_pkg::CRD_W-1:0] rand_coord();
    logic [vers_pkg::CRD_W-1:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3: c = $urandom();
      4, 5:       c = $urandom_range(0, 32'h0010_0000);          // small, Q16.16 ~ 16
      6:          c = -$urandom_range(0, 32'h0010_0000);
      7:          c = 32'h7FFF_FFFF;
      8:          c = 32'h8000_0000;
      default:    c = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
    return c;
  endfunction

  // raw angle data; upper bits are random garbage the block must ignore
  function automatic logic [vers_pkg::CFG_W-1:0] rand_angle();
    logic [vers_pkg::CFG_W-1:0] a;
    a = $urandom();
    case ($urandom_range(9))
      6:       a[vers_pkg::ANG_W-1:0] = '0;
      7:       a[vers_pkg::ANG_W-1:0] = 10'h1FF;                  // +511
      8:       a[vers_pkg::ANG_W-1:0] = 10'h200;                  // -512
      9:       a[vers_pkg::ANG_W-1:0] = vers_pkg::ANG_W'(90 * $urandom_range(0, 4));
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [vers_pkg::CFG_W-1:0] rand_scale();
    logic [vers_pkg::CFG_W-1:0] s;
    s = $urandom();
    case ($urandom_range(5))
      0, 1:    s[vers_pkg::SCL_W-1:0] = vers_pkg::SCL_W'($urandom_range(128, 512));
      2:       s[vers_pkg::SCL_W-1:0] = '0;
      3:       s[vers_pkg::SCL_W-1:0] = '1;
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [vers_pkg::CFG_W-1:0] rand_shift();
    if ($urandom_range(1)) return $urandom();
    return $urandom_range(0, 2000) - 1000;
  endfunction

  function automatic xform_setting_t rand_setting();
    xform_setting_t s;
    s.rot_x   = rand_angle();
    s.rot_y   = rand_angle();
    s.rot_z   = rand_angle();
    s.scale   = rand_scale();
    s.shift_x = rand_shift();
    s.shift_y = rand_shift();
    s.shift_z = rand_shift();
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Main stimulus
  //   directed: reset defaults, angle extremes (+511, -512, +-360), every
  //   quadrant, scale 0 / 1 / max, shifts at both rails and around the
  //   divisor rounding points, a write to the unused register index.
  //   random: three idle regimes (sender light / result side heavy, the
  //   reverse, none), each with several random register settings. Registers
  //   only change after the pipeline has drained.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    xform_setting_t s;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: near-identity rotation, unity scale, no shift
    send_vertex(mk_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_vertex(mk_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
    send_vertex(mk_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000));
    send_vertex(mk_vertex(32'hFFFF_0000, 32'h0000_8000, 32'h7FFF_8000));
    wait_drained();

    // angle extremes with max scale and rail shifts: saturation both ways
    s = '{32'd511, -32'sd512, 32'd360, 32'h0000_FFFF,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    load_setting(s, 1'b0);
    send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
    send_vertex(mk_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_vertex(mk_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_vertex(mk_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    wait_drained();

    // right angles, zero scale: only the rounded shift quotient survives
    s = '{32'd90, 32'd180, 32'd270, 32'h0, 32'd12, -32'sd13, 32'd37};
    load_setting(s, 1'b0);
    send_vertex(mk_vertex(32'd1000, 32'd2000, 32'd3000));
    send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    wait_drained();

    s = '{-32'sd360, -32'sd1, 32'd45, 32'd1, -32'sd12, 32'd38, -32'sd38};
    load_setting(s, 1'b0);
    send_vertex(mk_vertex(32'h0123_4567, 32'hFEDC_BA98, 32'h0000_FFFF));
    send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000));
    send_vertex(mk_vertex(32'h0000_00FF, 32'hFFFF_FF00, 32'h0000_0080));
    wait_drained();

    // remaining quadrants; stray write to the unused index must change nothing
    s = '{32'd135, 32'd225, 32'd315, 32'd512, 32'h0001_0000, -32'sd65536, 32'h0};
    load_setting(s, 1'b1);
    send_vertex(mk_vertex(32'h0010_0000, 32'h0020_0000, 32'h0030_0000));
    send_vertex(mk_vertex(32'hFFF0_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_vertex(mk_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333));
    wait_drained();

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0:       begin src_idle_pct = 13; sink_stall_pct = 68; end
        1:       begin src_idle_pct = 68; sink_stall_pct = 13; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      for (int k = 0; k < SETS_PER_REGIME; k++) begin
        wait_drained();
        load_setting(rand_setting(), $urandom_range(3) == 0);
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          // back the pipeline up while the sender keeps offering
          if (k == 0 && n == 10) hold_requests++;
          send_vertex(mk_vertex(rand_coord(), rand_coord(), rand_coord()));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[vertex_euler_rotate_scale_translate.f]
rtl/core/vers_pkg.sv
rtl/core/vers_trig.sv
rtl/core/vers_rot.sv
rtl/core/vers_div.sv
rtl/core/vers_fin.sv
rtl/core/vertex_euler_rotate_scale_translate.sv
rtl/core/vers_chk.sv
verif/vertex_euler_rotate_scale_translate_tb.sv
